// ----- rtl/core/sbl_pkg.sv -----
package sbl_pkg;

  // command bytes and reset value of the previous byte
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_LOAD   = 8'h42;
  localparam logic [7:0] CH_RUN    = 8'h52;
  localparam logic [7:0] LAST_INIT = 8'hFF;

  // header fields are four bytes, little-endian
  localparam logic [1:0] HDR_LAST_LANE = 2'd3;

  // result action codes
  localparam logic ACTION_WRITE  = 1'b0;
  localparam logic ACTION_LAUNCH = 1'b1;

  // deframer mode, one-hot
  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_LADDR = 5'b00010,
    MODE_LLEN  = 5'b00100,
    MODE_LDATA = 5'b01000,
    MODE_RADDR = 5'b10000
  } mode_t;

  // one result item
  typedef struct packed {
    logic        action;
    logic [31:0] address;
    logic [7:0]  data;
  } result_t;

  // result item with its valid flag, passed from decode to output buffer
  typedef struct packed {
    logic    valid;
    result_t item;
  } result_beat_t;

endpackage

// ----- rtl/core/sbl_byte_if.sv -----
interface sbl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/sbl_result_if.sv -----
interface sbl_result_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [31:0] address;
  logic [7:0]  data;

  modport source (output valid, output action, output address, output data, input ready);
  modport sink   (input valid, input action, input address, input data, output ready);
endinterface

// ----- rtl/core/serial_boot_loader_deframer.sv -----
// serial boot loader deframer
// serial: one received byte per item (valid, ready, rx_byte).
// host: write or launch results (valid, ready, action, address, data).
// a carriage return after 'B' opens a load: four address bytes, four length
// bytes (both little-endian), then length data bytes, each giving a write
// item to address plus offset. a carriage return after 'R' takes four
// address bytes and gives one launch item, then the block is idle again.
// path: a result reaches host through the input register, then the output
// register, passing through the skid entry first when host stalls.
// throughput: one byte per cycle while host takes items, set by the state update
// between the input register and the output register.
// reset sets the control state: idle, previous byte 0xFF, no items held.
// when host stalls, one extra result is held in a skid entry; after that
// serial ready falls until host takes an item. bytes that give no result
// still pass only when the output side has room.
module serial_boot_loader_deframer
  import sbl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  sbl_byte_if.sink      serial,
  sbl_result_if.source  host
);

  result_beat_t beat;
  logic         beat_ready;

  sbl_decode u_decode (
    .clk        (clk),
    .rst        (rst),
    .serial     (serial),
    .beat       (beat),
    .beat_ready (beat_ready)
  );

  sbl_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .beat       (beat),
    .beat_ready (beat_ready),
    .host       (host)
  );

endmodule

// ----- rtl/core/sbl_decode.sv -----
module sbl_decode
  import sbl_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  sbl_byte_if.sink       serial,
  output result_beat_t   beat,
  input  logic           beat_ready
);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // deframer state
  mode_t       mode, mode_next;
  logic [7:0]  last_byte, last_byte_next;
  logic [1:0]  hdr_idx, hdr_idx_next;
  logic [31:0] target, target_next;
  logic [31:0] length, length_next;
  logic [31:0] offset, offset_next;

  logic        adv;
  logic        lane_done;
  logic [31:0] offset_inc;
  logic [31:0] target_lane;
  logic [31:0] length_lane;

  // the registered item is consumed whenever the output side can take a result
  assign adv          = in_valid && beat_ready;
  assign serial.ready = !in_valid || beat_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (serial.ready) begin
      in_valid <= serial.valid;
    end
    if (serial.ready && serial.valid) begin
      in_byte <= serial.rx_byte;
    end
  end

  // header byte lane insertion
  always_comb begin
    target_lane = target;
    target_lane[{hdr_idx, 3'b000} +: 8] = in_byte;
    length_lane = length;
    length_lane[{hdr_idx, 3'b000} +: 8] = in_byte;
  end

  assign lane_done  = (hdr_idx == HDR_LAST_LANE);
  assign offset_inc = offset + 32'd1;

  // next state and result
  always_comb begin
    mode_next      = mode;
    last_byte_next = last_byte;
    hdr_idx_next   = hdr_idx;
    target_next    = target;
    length_next    = length;
    offset_next    = offset;
    beat.valid        = 1'b0;
    beat.item.action  = ACTION_WRITE;
    beat.item.address = target + offset;
    beat.item.data    = in_byte;

    unique case (mode)
      MODE_LADDR: begin
        target_next  = target_lane;
        hdr_idx_next = 2'(hdr_idx + 2'd1);
        if (lane_done) begin
          mode_next   = MODE_LLEN;
          length_next = '0;
        end
      end
      MODE_LLEN: begin
        length_next  = length_lane;
        hdr_idx_next = 2'(hdr_idx + 2'd1);
        if (lane_done) begin
          offset_next = '0;
          mode_next   = (length_lane == '0) ? MODE_IDLE : MODE_LDATA;
        end
      end
      MODE_LDATA: begin
        beat.valid  = 1'b1;
        offset_next = offset_inc;
        if (offset_inc == length) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_RADDR: begin
        target_next  = target_lane;
        hdr_idx_next = 2'(hdr_idx + 2'd1);
        if (lane_done) begin
          mode_next         = MODE_IDLE;
          beat.valid        = 1'b1;
          beat.item.action  = ACTION_LAUNCH;
          beat.item.address = target_lane;
          beat.item.data    = '0;
        end
      end
      default: begin
        // idle command watch: carriage return after a command letter
        if (in_byte == CH_CR && (last_byte == CH_LOAD || last_byte == CH_RUN)) begin
          mode_next    = (last_byte == CH_LOAD) ? MODE_LADDR : MODE_RADDR;
          hdr_idx_next = '0;
          target_next  = '0;
        end else begin
          mode_next = MODE_IDLE;
        end
        last_byte_next = in_byte;
      end
    endcase

    if (!adv) begin
      beat.valid = 1'b0;
    end
  end

  // state update on each consumed item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_IDLE;
      last_byte <= LAST_INIT;
      hdr_idx   <= '0;
      target    <= '0;
      length    <= '0;
      offset    <= '0;
    end else if (adv) begin
      mode      <= mode_next;
      last_byte <= last_byte_next;
      hdr_idx   <= hdr_idx_next;
      target    <= target_next;
      length    <= length_next;
      offset    <= offset_next;
    end
  end

endmodule

// ----- rtl/core/sbl_out_buf.sv -----
module sbl_out_buf
  import sbl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  result_beat_t  beat,
  output logic          beat_ready,
  sbl_result_if.source  host
);

  // output register and skid entry
  logic    main_valid;
  result_t main_item;
  logic    skid_valid;
  result_t skid_item;
  logic    pop;
  logic    fill;

  assign beat_ready   = !skid_valid;
  assign pop          = main_valid && host.ready;
  assign fill         = beat.valid && beat_ready;
  assign host.valid   = main_valid;
  assign host.action  = main_item.action;
  assign host.address = main_item.address;
  assign host.data    = main_item.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop && skid_valid) begin
      // drain: skid moves up into the output register
      main_item  <= skid_item;
      skid_valid <= 1'b0;
    end else if (fill && (!main_valid || pop)) begin
      // fill: straight to output if free
      main_item  <= beat.item;
      main_valid <= 1'b1;
    end else if (fill) begin
      // output busy, park in skid
      skid_item  <= beat.item;
      skid_valid <= 1'b1;
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule
